@@ rtl/joint_angle_kalman_smoother_assert.svh @@
// ----------------------------------------------------------------------------
// Joint angle smoother assertion macros
// Shared concurrent assertion forms, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef JOINT_ANGLE_KALMAN_SMOOTHER_ASSERT_SVH
`define JOINT_ANGLE_KALMAN_SMOOTHER_ASSERT_SVH

// same-cycle implication
`define JAKS_ASSERT_NOW(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define JAKS_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

@@ rtl/jaks_pkg.sv @@
// ----------------------------------------------------------------------------
// Joint angle smoother package
// Shared constants, register codes, sequencer state and control bundles.
// ----------------------------------------------------------------------------
package jaks_pkg;

   localparam int ANGLE_WIDTH_DEF   = 16;
   localparam int VAR_FRAC_BITS_DEF = 16;
   localparam int CFG_WIDTH         = 16;
   localparam int CFG_INDEX_BITS    = 2;
   localparam int SEL_BITS          = 2;
   localparam int GAIN_BITS         = 16;
   localparam int NUM_FILTERS       = 4;
   localparam int NUM_HELD          = 3;

   // one quotient bit per cycle, one extra bit for rounding
   localparam int DIV_STEPS    = GAIN_BITS + 2;
   // one multiplier bit per cycle over the 17-bit complement gain
   localparam int MUL_STEPS    = GAIN_BITS + 1;
   // load, prep, then the divide steps
   localparam int PHASE_CYCLES = DIV_STEPS + 2;
   localparam int WB_CYCLE     = MUL_STEPS + 1;
   localparam int CNT_W        = $clog2(PHASE_CYCLES);
   localparam int PHASE_W      = $clog2(NUM_FILTERS + 1);

   localparam logic [CFG_INDEX_BITS-1:0] REG_NOISE_Q_BASE  = 2'd0;
   localparam logic [CFG_INDEX_BITS-1:0] REG_NOISE_Q_WRIST = 2'd1;
   localparam logic [CFG_INDEX_BITS-1:0] REG_MEAS_NOISE    = 2'd2;

   localparam logic [CFG_WIDTH-1:0] NOISE_Q_BASE_RST  = 16'd66;
   localparam logic [CFG_WIDTH-1:0] NOISE_Q_WRIST_RST = 16'd655;
   localparam logic [CFG_WIDTH-1:0] MEAS_NOISE_RST    = 16'd6554;

   localparam logic [SEL_BITS-1:0] SEL_NONE = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic step;
   } div_ctl_type;

   typedef struct packed {
      logic load;
      logic step;
   } mul_ctl_type;

endpackage

@@ rtl/jaks_div.sv @@
// ----------------------------------------------------------------------------
// Kalman gain divider
// Bit-serial restoring divide, k = round(pp / (pp + r)) in Q0.16, saturated.
// ----------------------------------------------------------------------------
module jaks_div #(
   parameter int VAR_FRAC_BITS = jaks_pkg::VAR_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  jaks_pkg::div_ctl_type         ctl,
   input  logic [VAR_FRAC_BITS+1:0]      pp,
   input  logic [VAR_FRAC_BITS+1:0]      rv,
   output logic [jaks_pkg::GAIN_BITS-1:0] gain,
   output logic [VAR_FRAC_BITS+1:0]      pp_out
);
   import jaks_pkg::*;

   localparam int VW = VAR_FRAC_BITS + 2;
   localparam int DW = VW + 1;
   localparam int QW = DIV_STEPS;

   logic [VW-1:0] pp_ff,  pp_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [QW-1:0] num_ff, num_in;
   logic [QW-1:0] quo_ff, quo_in;

   logic [DW:0]   trial;
   logic [DW:0]   diff;
   logic          ge;
   logic [QW:0]   rnd;

   always_comb begin
      trial  = {rem_ff, num_ff[QW-1]};
      diff   = trial - {1'b0, den_ff};
      ge     = trial >= {1'b0, den_ff};
      pp_in  = pp_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      num_in = num_ff;
      quo_in = quo_ff;
      if (ctl.load) begin
         pp_in = pp;
      end
      if (ctl.prep) begin
         den_in = {1'b0, pp_ff} + {1'b0, rv};
         // numerator is pp << (QW-1); top bits seed the remainder
         rem_in = DW'(pp_ff[VW-1:1]);
         num_in = {pp_ff[0], {(QW-1){1'b0}}};
         quo_in = '0;
      end else if (ctl.step) begin
         rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
         num_in = {num_ff[QW-2:0], 1'b0};
         quo_in = {quo_ff[QW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      pp_ff  <= pp_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
   end

   // extra quotient bit: round half up is (t + 1) >> 1
   always_comb begin
      rnd = ({1'b0, quo_ff} + (QW+1)'(1)) >> 1;
      if (den_ff == '0) begin
         gain = '0;
      end else if (rnd[QW:GAIN_BITS] != '0) begin
         gain = '1;
      end else begin
         gain = rnd[GAIN_BITS-1:0];
      end
   end

   assign pp_out = pp_ff;

endmodule

@@ rtl/jaks_mul.sv @@
// ----------------------------------------------------------------------------
// Estimate and variance update multiplier
// Two shift-add products in lockstep: k * (m - x) and (1 - k) * pp.
// ----------------------------------------------------------------------------
module jaks_mul #(
   parameter int ANGLE_WIDTH   = jaks_pkg::ANGLE_WIDTH_DEF,
   parameter int VAR_FRAC_BITS = jaks_pkg::VAR_FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  jaks_pkg::mul_ctl_type          ctl,
   input  logic [jaks_pkg::GAIN_BITS-1:0] gain,
   input  logic signed [ANGLE_WIDTH:0]    diff,
   input  logic [VAR_FRAC_BITS+1:0]       pp,
   output logic signed [ANGLE_WIDTH:0]    corr,
   output logic [VAR_FRAC_BITS+1:0]       var_new
);
   import jaks_pkg::*;

   localparam int AW  = ANGLE_WIDTH;
   localparam int VW  = VAR_FRAC_BITS + 2;
   localparam int GW  = GAIN_BITS + 1;
   localparam int PDW = AW + GAIN_BITS + 1;
   localparam int PPW = VW + GW;
   localparam logic [PDW-1:0] HALF_D = PDW'(1) << (GAIN_BITS - 1);
   localparam logic [PPW-1:0] HALF_P = PPW'(1) << (GAIN_BITS - 1);

   logic [GAIN_BITS-1:0]  k_ff,    k_in;
   logic [GW-1:0]         g_ff,    g_in;
   logic signed [PDW-1:0] dmc_ff,  dmc_in;
   logic [PPW-1:0]        pmc_ff,  pmc_in;
   logic signed [PDW-1:0] accd_ff, accd_in;
   logic [PPW-1:0]        accp_ff, accp_in;

   logic [PDW-1:0] rnd_d;
   logic [PPW-1:0] rnd_p;

   always_comb begin
      k_in    = k_ff;
      g_in    = g_ff;
      dmc_in  = dmc_ff;
      pmc_in  = pmc_ff;
      accd_in = accd_ff;
      accp_in = accp_ff;
      if (ctl.load) begin
         k_in    = gain;
         g_in    = {1'b1, {GAIN_BITS{1'b0}}} - {1'b0, gain};
         dmc_in  = {{(PDW-AW-1){diff[AW]}}, diff};
         pmc_in  = PPW'(pp);
         accd_in = '0;
         accp_in = '0;
      end else if (ctl.step) begin
         if (k_ff[0]) begin
            accd_in = accd_ff + dmc_ff;
         end
         if (g_ff[0]) begin
            accp_in = accp_ff + pmc_ff;
         end
         k_in   = k_ff >> 1;
         g_in   = g_ff >> 1;
         dmc_in = dmc_ff <<< 1;
         pmc_in = pmc_ff << 1;
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      g_ff    <= g_in;
      dmc_ff  <= dmc_in;
      pmc_ff  <= pmc_in;
      accd_ff <= accd_in;
      accp_ff <= accp_in;
   end

   // round half up, floor shift by 16
   assign rnd_d   = accd_ff + HALF_D;
   assign corr    = rnd_d[PDW-1:GAIN_BITS];
   assign rnd_p   = accp_ff + HALF_P;
   // never above pp, so the low bits are the whole value
   assign var_new = rnd_p[VW+GAIN_BITS-1:GAIN_BITS];

endmodule

@@ rtl/joint_angle_kalman_smoother.sv @@
// Response: rsp_tvalid rises after phase 4's writeback, once the result register is free.
// Pacing: a new sample is taken only after the previous run ends; four gain divides at one quotient bit per cycle
//   set the pace, overlapped with the multiplies of the previous filter.
// Result register frees the input side: the next sample is taken while a result waits.
// Reset (synchronous, active high): estimates zero, variances 1.0, held targets zero,
//   noise registers to their defaults, no result pending.
// ----------------------------------------------------------------------------
// Joint angle smoother
// Four scalar random-walk Kalman filters sharing one serial divider and one
// serial dual multiplier; one smoothed pose per teleoperation sample.
// ----------------------------------------------------------------------------
`include "joint_angle_kalman_smoother_assert.svh"

module joint_angle_kalman_smoother #(
   parameter int ANGLE_WIDTH   = jaks_pkg::ANGLE_WIDTH_DEF,
   parameter int VAR_FRAC_BITS = jaks_pkg::VAR_FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration writes
   input  logic                                 csr_we,
   input  logic [jaks_pkg::CFG_INDEX_BITS-1:0]  csr_index,
   input  logic [jaks_pkg::CFG_WIDTH-1:0]       csr_wdata,
   // sample beats
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((2*ANGLE_WIDTH+7)/8)*8-1:0]   req_tdata,  // roll_angle, pitch_angle
   input  logic [jaks_pkg::SEL_BITS-1:0]        req_tuser,  // joint_select
   // smoothed pose beats
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [((4*ANGLE_WIDTH+7)/8)*8-1:0]   rsp_tdata   // joint1..joint4_angle
);
   import jaks_pkg::*;

   localparam int AW    = ANGLE_WIDTH;
   localparam int VF    = VAR_FRAC_BITS;
   localparam int VW    = VF + 2;
   localparam int RSP_W = ((4*ANGLE_WIDTH+7)/8)*8;

   localparam logic [VW-1:0]      VAR_ONE   = VW'(1) << VF;
   localparam logic signed [AW-1:0] ANG_MAX = {1'b0, {(AW-1){1'b1}}};
   localparam logic signed [AW-1:0] ANG_MIN = {1'b1, {(AW-1){1'b0}}};
   localparam logic [CNT_W-1:0]   CNT_LAST  = CNT_W'(PHASE_CYCLES - 1);
   localparam logic [CNT_W-1:0]   CNT_PREP  = CNT_W'(1);
   localparam logic [CNT_W-1:0]   CNT_MLAST = CNT_W'(MUL_STEPS);
   localparam logic [CNT_W-1:0]   CNT_WB    = CNT_W'(WB_CYCLE);
   localparam logic [PHASE_W-1:0] PH_LAST   = PHASE_W'(NUM_FILTERS);

   // ---------------------------------------------------------------- config
   logic [CFG_WIDTH-1:0] q_base_ff,  q_base_in;
   logic [CFG_WIDTH-1:0] q_wrist_ff, q_wrist_in;
   logic [CFG_WIDTH-1:0] r_ff,       r_in;

   always_comb begin
      q_base_in  = q_base_ff;
      q_wrist_in = q_wrist_ff;
      r_in       = r_ff;
      if (csr_we) begin
         case (csr_index)
            REG_NOISE_Q_BASE:  q_base_in  = csr_wdata;
            REG_NOISE_Q_WRIST: q_wrist_in = csr_wdata;
            REG_MEAS_NOISE:    r_in       = csr_wdata;
            default: ;  // no register there, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_base_ff  <= NOISE_Q_BASE_RST;
         q_wrist_ff <= NOISE_Q_WRIST_RST;
         r_ff       <= MEAS_NOISE_RST;
      end else begin
         q_base_ff  <= q_base_in;
         q_wrist_ff <= q_wrist_in;
         r_ff       <= r_in;
      end
   end

   // ------------------------------------------------------------- sequencer
   // Phase p (0..4), by counter value within the phase:
   //   divider works on filter p < 4  (load at 0, prep at 1, steps 2..19)
   //   multiplier works on filter p-1 (load at 0, steps 1..17, writeback 18)
   // Phase 4 ends at its writeback cycle and hands over to DONE.
   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff,   cnt_in;
   logic [PHASE_W-1:0]   phase_ff, phase_in;

   logic        accept;
   logic        run, div_on, mul_on;
   logic        wb;
   logic        rsp_load;
   logic        rsp_valid_ff, rsp_valid_in;
   div_ctl_type div_ctl;
   mul_ctl_type mul_ctl;

   assign accept = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (phase_ff == PH_LAST && cnt_ff == CNT_WB) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      run          = state_ff == ST_RUN;
      div_on       = phase_ff < PH_LAST;
      mul_on       = phase_ff != '0;
      req_tready   = state_ff == ST_IDLE;
      rsp_load     = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);
      div_ctl.load = run && div_on && cnt_ff == '0;
      div_ctl.prep = run && div_on && cnt_ff == CNT_PREP;
      div_ctl.step = run && div_on && cnt_ff > CNT_PREP;
      mul_ctl.load = run && mul_on && cnt_ff == '0;
      mul_ctl.step = run && mul_on && cnt_ff != '0 && cnt_ff <= CNT_MLAST;
      wb           = run && mul_on && cnt_ff == CNT_WB;
   end

   always_comb begin
      cnt_in   = cnt_ff;
      phase_in = phase_ff;
      if (accept) begin
         cnt_in   = '0;
         phase_in = '0;
      end else if (run) begin
         if (cnt_ff == CNT_LAST) begin
            cnt_in   = '0;
            phase_in = phase_ff + PHASE_W'(1);
         end else begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         phase_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         phase_ff <= phase_in;
      end
   end

   // ---------------------------------------------------------- filter state
   logic signed [AW-1:0] est_ff  [NUM_FILTERS];
   logic [VW-1:0]        var_ff  [NUM_FILTERS];
   logic signed [AW-1:0] held_ff [NUM_HELD];
   logic signed [AW-1:0] roll_ff, roll_in;

   logic signed [AW-1:0] req_roll, req_pitch;
   logic [1:0]           div_idx, mul_idx;

   assign req_roll  = req_tdata[AW-1:0];
   assign req_pitch = req_tdata[2*AW-1:AW];
   assign div_idx   = phase_ff[1:0];
   assign mul_idx   = phase_ff[1:0] - 2'd1;
   assign roll_in   = accept ? req_roll : roll_ff;

   always_ff @(posedge clock) begin
      roll_ff <= roll_in;
   end

   // predicted variance for the divider: pp = sat(p + q), noise aligned to Q2.VF
   logic [CFG_WIDTH-1:0]    q_sel;
   logic [VF+CFG_WIDTH-1:0] q_wide, r_wide;
   logic [VW-1:0]           q_var, r_var;
   logic [VW:0]             pp_sum;
   logic [VW-1:0]           pp_div;

   always_comb begin
      q_sel  = div_idx[1] ? q_wrist_ff : q_base_ff;
      q_wide = {q_sel, {VF{1'b0}}};
      r_wide = {r_ff, {VF{1'b0}}};
      q_var  = VW'(q_wide[VF+CFG_WIDTH-1:CFG_WIDTH]);
      r_var  = VW'(r_wide[VF+CFG_WIDTH-1:CFG_WIDTH]);
      pp_sum = {1'b0, var_ff[div_idx]} + {1'b0, q_var};
      pp_div = pp_sum[VW] ? '1 : pp_sum[VW-1:0];
   end

   // innovation for the multiplier
   logic signed [AW-1:0] target;
   logic signed [AW:0]   diff;

   always_comb begin
      case (mul_idx)
         2'd0:    target = roll_ff;
         2'd1:    target = held_ff[0];
         2'd2:    target = held_ff[1];
         2'd3:    target = held_ff[2];
         default: target = roll_ff;
      endcase
      diff = {target[AW-1], target} - {est_ff[mul_idx][AW-1], est_ff[mul_idx]};
   end

   // ----------------------------------------------------------- datapath
   logic [GAIN_BITS-1:0] gain;
   logic [VW-1:0]        pp_mul;
   logic signed [AW:0]   corr;
   logic [VW-1:0]        var_in;

   jaks_div #(
      .VAR_FRAC_BITS (VAR_FRAC_BITS)
   ) u_div (
      .clock  (clock),
      .ctl    (div_ctl),
      .pp     (pp_div),
      .rv     (r_var),
      .gain   (gain),
      .pp_out (pp_mul)
   );

   jaks_mul #(
      .ANGLE_WIDTH   (ANGLE_WIDTH),
      .VAR_FRAC_BITS (VAR_FRAC_BITS)
   ) u_mul (
      .clock   (clock),
      .ctl     (mul_ctl),
      .gain    (gain),
      .diff    (diff),
      .pp      (pp_mul),
      .corr    (corr),
      .var_new (var_in)
   );

   // corrected estimate, saturated to the angle range
   logic signed [AW+1:0] est_sum;
   logic signed [AW-1:0] est_in;

   always_comb begin
      est_sum = {{2{est_ff[mul_idx][AW-1]}}, est_ff[mul_idx]} + {corr[AW], corr};
      if (est_sum[AW+1:AW-1] == '0 || est_sum[AW+1:AW-1] == '1) begin
         est_in = est_sum[AW-1:0];
      end else if (est_sum[AW+1]) begin
         est_in = ANG_MIN;
      end else begin
         est_in = ANG_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_FILTERS; i++) begin
            est_ff[i] <= '0;
            var_ff[i] <= VAR_ONE;
         end
         for (int i = 0; i < NUM_HELD; i++) begin
            held_ff[i] <= '0;
         end
      end else begin
         if (accept && req_tuser != SEL_NONE) begin
            held_ff[req_tuser] <= req_pitch;
         end
         if (wb) begin
            est_ff[mul_idx] <= est_in;
            var_ff[mul_idx] <= var_in;
         end
      end
   end

   // ------------------------------------------------------- result register
   logic [RSP_W-1:0] rsp_data_ff,  rsp_data_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_W'({est_ff[3], est_ff[2], est_ff[1], est_ff[0]});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ------------------------------------------------------------ assertions
   `JAKS_ASSERT_NEXT(a_accept_starts, clock, reset, accept,
      state_ff == ST_RUN && phase_ff == '0 && cnt_ff == '0,
      "sample taken without starting phase zero")
   `JAKS_ASSERT_NOW(a_wb_mul_idle, clock, reset, wb,
      !mul_ctl.step && !mul_ctl.load,
      "writeback while the multiplier is still running")
   `JAKS_ASSERT_NEXT(a_done_waits, clock, reset,
      state_ff == ST_DONE && rsp_valid_ff && !rsp_tready,
      state_ff == ST_DONE && rsp_valid_ff,
      "pending result overwritten")
   `JAKS_ASSERT_NOW(a_rsp_drop, clock, reset,
      $fell(rsp_valid_ff) && !$past(reset),
      $past(rsp_tready),
      "result dropped without a beat")

endmodule
